// ===== hdl/esw_pkg.sv =====
// ----------------------------------------------------------------------------
// esw_pkg
// shared widths, reset values, register indexes and controller commands
// ----------------------------------------------------------------------------
package esw_pkg;

  localparam int unsigned LoopDepth = 16384;
  localparam int unsigned NumLoops  = 3;
  localparam int unsigned RamDepth  = NumLoops * LoopDepth;
  localparam int unsigned RamAw     = $clog2(RamDepth);
  localparam int unsigned WordAw    = $clog2(LoopDepth);
  localparam int unsigned LenW      = WordAw + 1;
  localparam int unsigned PhaseW    = WordAw + 16;
  localparam int unsigned RpmW      = 24;
  localparam int unsigned DivW      = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [7:0] MaxRpm = 8'd120;
  localparam logic [7:0] MinRpm = 8'd25;

  localparam logic [7:0]    LrLowRst   = 8'd25;
  localparam logic [7:0]    LrMidRst   = 8'd40;
  localparam logic [7:0]    LrHighRst  = 8'd65;
  localparam logic [15:0]   GainLowRst = 16'd16384;
  localparam logic [15:0]   GainMidRst = 16'd19661;
  localparam logic [15:0]   GainHiRst  = 16'd32768;
  localparam logic [15:0]   RateRst    = 16'd315;
  localparam logic [LenW-1:0] LenRst   = LenW'(LoopDepth);

  localparam logic [CfgIdxW-1:0] CFG_LOOP_RPM_LOW  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOOP_RPM_MID  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOOP_RPM_HIGH = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_LOW      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_MID      = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_HIGH     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_APPROACH_RATE = 3'd6;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic [1:0] LOOP_NONE = 2'd3;

  typedef enum logic [4:0] {
    OP_IDLE, OP_LOAD, OP_RPM_MUL, OP_RPM_UPD, OP_BAND,
    OP_INC_GO, OP_INC_WAIT, OP_MOD_GO, OP_MOD_WAIT,
    OP_RD_A, OP_RD_B, OP_RD_END, OP_IMUL, OP_ISUM, OP_GMUL, OP_GSTO,
    OP_LERP_GO, OP_LERP_WAIT, OP_MIX_L, OP_MIX_H, OP_MIX_SUM, OP_OUT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic func;
    logic two_loops;
    logic second;
    logic lerp_ok;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/esw_ram.sv =====
// ----------------------------------------------------------------------------
// esw_ram
// single-port ram, one write or one registered read per cycle
// ----------------------------------------------------------------------------
module esw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ===== hdl/esw_div.sv =====
// ----------------------------------------------------------------------------
// esw_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module esw_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [esw_pkg::DivW-1:0]   num_i,
  input  logic [esw_pkg::DivW-2:0]   den_i,
  output logic                       done_o,
  output logic [esw_pkg::DivW-1:0]   quot_o,
  output logic [esw_pkg::DivW-2:0]   rem_o
);
  import esw_pkg::*;

  localparam int unsigned CntW = $clog2(DivW);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] qn_q;
  logic [DivW-2:0] rem_q, den_q;
  logic [DivW-1:0] trial;
  logic [DivW-1:0] diff;
  logic            fits;

  assign trial = {rem_q, qn_q[DivW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      qn_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DivW-2:0] : trial[DivW-2:0];
      qn_q  <= {qn_q[DivW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = qn_q;
  assign rem_o  = rem_q;

endmodule

// ===== hdl/esw_ctrl.sv =====
// ----------------------------------------------------------------------------
// esw_ctrl
// sequencer: steps one item through the datapath
// ----------------------------------------------------------------------------
module esw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  esw_pkg::status_t status_i,
  output esw_pkg::cmd_t    cmd_o
);
  import esw_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_LOAD, S_RPM_MUL, S_RPM_UPD, S_BAND,
    S_INC_GO, S_INC_WAIT, S_MOD_GO, S_MOD_WAIT,
    S_RD_A, S_RD_B, S_RD_END, S_IMUL, S_ISUM, S_GMUL, S_GSTO,
    S_LERP_GO, S_LERP_WAIT, S_MIX_L, S_MIX_H, S_MIX_SUM, S_OUT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (in_valid_i) state_d = S_DECODE;
      S_DECODE:    state_d = (status_i.func == FUNC_SAMPLE) ? S_RPM_MUL : S_LOAD;
      S_LOAD:      state_d = S_IDLE;
      S_RPM_MUL:   state_d = S_RPM_UPD;
      S_RPM_UPD:   state_d = S_BAND;
      S_BAND:      state_d = S_INC_GO;
      S_INC_GO:    state_d = S_INC_WAIT;
      S_INC_WAIT:  if (status_i.div_done) state_d = S_MOD_GO;
      S_MOD_GO:    state_d = S_MOD_WAIT;
      S_MOD_WAIT:  if (status_i.div_done) state_d = S_RD_A;
      S_RD_A:      state_d = S_RD_B;
      S_RD_B:      state_d = S_RD_END;
      S_RD_END:    state_d = S_IMUL;
      S_IMUL:      state_d = S_ISUM;
      S_ISUM:      state_d = S_GMUL;
      S_GMUL:      state_d = S_GSTO;
      S_GSTO: begin
        if (status_i.two_loops && !status_i.second) state_d = S_INC_GO;
        else if (status_i.two_loops && status_i.lerp_ok) state_d = S_LERP_GO;
        else state_d = S_MIX_L;
      end
      S_LERP_GO:   state_d = S_LERP_WAIT;
      S_LERP_WAIT: if (status_i.div_done) state_d = S_MIX_L;
      S_MIX_L:     state_d = S_MIX_H;
      S_MIX_H:     state_d = S_MIX_SUM;
      S_MIX_SUM:   state_d = S_OUT;
      S_OUT:       if (status_i.out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.capture = in_ready_o && in_valid_i;
    unique case (state_q)
      S_LOAD:      cmd_o.op = OP_LOAD;
      S_RPM_MUL:   cmd_o.op = OP_RPM_MUL;
      S_RPM_UPD:   cmd_o.op = OP_RPM_UPD;
      S_BAND:      cmd_o.op = OP_BAND;
      S_INC_GO:    cmd_o.op = OP_INC_GO;
      S_INC_WAIT:  cmd_o.op = OP_INC_WAIT;
      S_MOD_GO:    cmd_o.op = OP_MOD_GO;
      S_MOD_WAIT:  cmd_o.op = OP_MOD_WAIT;
      S_RD_A:      cmd_o.op = OP_RD_A;
      S_RD_B:      cmd_o.op = OP_RD_B;
      S_RD_END:    cmd_o.op = OP_RD_END;
      S_IMUL:      cmd_o.op = OP_IMUL;
      S_ISUM:      cmd_o.op = OP_ISUM;
      S_GMUL:      cmd_o.op = OP_GMUL;
      S_GSTO:      cmd_o.op = OP_GSTO;
      S_LERP_GO:   cmd_o.op = OP_LERP_GO;
      S_LERP_WAIT: cmd_o.op = OP_LERP_WAIT;
      S_MIX_L:     cmd_o.op = OP_MIX_L;
      S_MIX_H:     cmd_o.op = OP_MIX_H;
      S_MIX_SUM:   cmd_o.op = OP_MIX_SUM;
      S_OUT:       cmd_o.op = OP_OUT;
      default:     cmd_o.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/esw_dp.sv =====
// ----------------------------------------------------------------------------
// esw_dp
// datapath: registers, shared multiplier, divider and wave memory
// ----------------------------------------------------------------------------
module esw_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  esw_pkg::cmd_t                cmd_i,
  output esw_pkg::status_t             status_o,
  input  logic                         cfg_we_i,
  input  logic [esw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [esw_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         item_func_i,
  input  logic                         item_rev_up_i,
  input  logic [1:0]                   item_loop_select_i,
  input  logic [esw_pkg::WordAw-1:0]   item_word_address_i,
  input  logic [15:0]                  item_word_value_i,
  input  logic                         item_last_word_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [15:0]                  out_sample_o,
  output logic [1:0]                   out_band_o
);
  import esw_pkg::*;

  // configuration
  logic [7:0]  lr_q   [NumLoops];
  logic [15:0] gain_q [NumLoops];
  logic [15:0] rate_q;

  // synth state
  logic [RpmW-1:0]   rpm_q;
  logic [1:0]        band_q;
  logic [PhaseW-1:0] phase_q [NumLoops];
  logic [LenW-1:0]   len_q   [NumLoops];

  // captured word
  logic              func_q, rev_q, last_q;
  logic [1:0]        sel_q;
  logic [WordAw-1:0] addr_q;
  logic [15:0]       wval_q;

  // working registers
  logic [1:0]         lp_q;
  logic               second_q;
  logic [RpmW-1:0]    inc_q;
  logic signed [15:0] a_q, b_q;
  logic signed [16:0] i_q;
  logic signed [33:0] wa_q, wb_q;
  logic signed [25:0] lerp_q;
  logic signed [52:0] prod_q;
  logic signed [63:0] acc_q;
  logic               out_valid_q;
  logic [15:0]        out_sample_q;
  logic [1:0]         out_band_q;

  op_e op;
  assign op = cmd_i.op;

  // ---- selections ----
  logic [7:0]        lr_lp, lr_cur, lr_up, lr_div;
  logic [15:0]       gain_lp;
  logic [PhaseW-1:0] phase_lp;
  logic [LenW-1:0]   len_lp;
  logic              two_loops;

  assign lr_lp    = lr_q[lp_q];
  assign gain_lp  = gain_q[lp_q];
  assign phase_lp = phase_q[lp_q];
  assign len_lp   = len_q[lp_q];
  assign lr_cur   = lr_q[band_q];
  assign lr_up    = (band_q == 2'd0) ? lr_q[1] : lr_q[2];
  assign lr_div   = (lr_lp == 8'd0) ? 8'd1 : lr_lp;
  assign two_loops = (band_q != 2'd2);

  // rpm step
  logic [RpmW-1:0] target;
  logic            rising;
  logic [RpmW-1:0] rpm_gap;
  assign target  = {(rev_q ? MaxRpm : MinRpm), 16'd0};
  assign rising  = target >= rpm_q;
  assign rpm_gap = rising ? (target - rpm_q) : (rpm_q - target);

  // band move by at most one
  logic [1:0] band_new;
  always_comb begin
    band_new = band_q;
    case (band_q)
      2'd0: if (rpm_q > {lr_q[1], 16'd0}) band_new = 2'd1;
      2'd1: begin
        if (rpm_q > {lr_q[2], 16'd0}) band_new = 2'd2;
        else if (rpm_q < {lr_q[1], 16'd0}) band_new = 2'd0;
      end
      2'd2: if (rpm_q < {lr_q[2], 16'd0}) band_new = 2'd1;
      default: band_new = band_q;
    endcase
  end

  // interpolation points
  logic [WordAw-1:0] idx, nxt;
  logic [15:0]       frac;
  assign idx  = phase_lp[PhaseW-1:16];
  assign frac = phase_lp[15:0];
  assign nxt  = ({1'b0, idx} + 1'b1 == len_lp) ? '0 : idx + 1'b1;

  // crossfade numerator
  logic signed [25:0] lx;
  logic [25:0]        lmag;
  logic               lerp_ok;
  assign lx      = $signed({2'b00, rpm_q}) - $signed({2'b00, lr_cur, 16'd0});
  assign lmag    = lx[25] ? 26'(-lx) : 26'(lx);
  assign lerp_ok = lr_up > lr_cur;

  // ---- shared multiplier ----
  logic signed [34:0] mul_a, mix_diff;
  logic signed [17:0] mul_b;
  logic signed [16:0] dab;
  assign dab      = $signed({b_q[15], b_q}) - $signed({a_q[15], a_q});
  assign mix_diff = two_loops ? ($signed({wb_q[33], wb_q}) - $signed({wa_q[33], wa_q}))
                              : '0;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_RPM_MUL: begin
        mul_a = $signed({11'd0, rpm_gap});
        mul_b = $signed({2'b00, rate_q});
      end
      OP_IMUL: begin
        mul_a = 35'(dab);
        mul_b = $signed({2'b00, frac});
      end
      OP_GMUL: begin
        mul_a = 35'(i_q);
        mul_b = $signed({2'b00, gain_lp});
      end
      OP_MIX_L: begin
        mul_a = mix_diff;
        mul_b = $signed({2'b00, lerp_q[15:0]});
      end
      OP_MIX_H: begin
        // upper part of the crossfade factor carries its sign
        mul_a = mix_diff;
        mul_b = 18'($signed(lerp_q[25:16]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---- divider ----
  logic            div_start, div_done;
  logic [DivW-1:0] div_num, div_quot;
  logic [DivW-2:0] div_den, div_rem;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (op)
      OP_INC_GO: begin
        div_start = 1'b1;
        div_num   = {8'd0, rpm_q};
        div_den   = {23'd0, lr_div};
      end
      OP_MOD_GO: begin
        div_start = 1'b1;
        div_num   = {2'b00, phase_lp} + {8'd0, inc_q};
        div_den   = {len_lp, 16'd0};
      end
      OP_LERP_GO: begin
        div_start = 1'b1;
        div_num   = {6'd0, lmag};
        div_den   = {23'd0, 8'(lr_up - lr_cur)};
      end
      default: div_start = 1'b0;
    endcase
  end

  esw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  // ---- wave memory ----
  logic             ram_we;
  logic [RamAw-1:0] ram_addr;
  logic [15:0]      ram_rdata;
  assign ram_we   = (op == OP_LOAD) && (sel_q != LOOP_NONE);
  always_comb begin
    case (op)
      OP_LOAD: ram_addr = {sel_q, addr_q};
      OP_RD_B: ram_addr = {lp_q, nxt};
      default: ram_addr = {lp_q, idx};
    endcase
  end

  esw_ram #(.Width(16), .Depth(RamDepth)) u_wave_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (wval_q),
    .rdata_o (ram_rdata)
  );

  // ---- output rounding and saturation ----
  logic signed [63:0] acc_bias;
  logic signed [32:0] sdiv;
  logic [15:0]        sat;
  logic signed [17:0] isum;
  assign acc_bias = acc_q + (acc_q[63] ? 64'sh7FFF_FFFF : 64'sd0);
  assign sdiv     = acc_bias[63:31];
  always_comb begin
    if (sdiv > 33'sd32767) sat = 16'h7FFF;
    else if (sdiv < -33'sd32768) sat = 16'h8000;
    else sat = sdiv[15:0];
  end
  assign isum = $signed({{2{a_q[15]}}, a_q}) + $signed(prod_q[33:16]);

  // ---- control registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q[0]     <= LrLowRst;
      lr_q[1]     <= LrMidRst;
      lr_q[2]     <= LrHighRst;
      gain_q[0]   <= GainLowRst;
      gain_q[1]   <= GainMidRst;
      gain_q[2]   <= GainHiRst;
      rate_q      <= RateRst;
      rpm_q       <= {MinRpm, 16'd0};
      band_q      <= '0;
      for (int i = 0; i < NumLoops; i++) begin
        phase_q[i] <= '0;
        len_q[i]   <= LenRst;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LOOP_RPM_LOW:  lr_q[0]   <= cfg_data_i[7:0];
          CFG_LOOP_RPM_MID:  lr_q[1]   <= cfg_data_i[7:0];
          CFG_LOOP_RPM_HIGH: lr_q[2]   <= cfg_data_i[7:0];
          CFG_GAIN_LOW:      gain_q[0] <= cfg_data_i;
          CFG_GAIN_MID:      gain_q[1] <= cfg_data_i;
          CFG_GAIN_HIGH:     gain_q[2] <= cfg_data_i;
          CFG_APPROACH_RATE: rate_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (op == OP_LOAD && sel_q != LOOP_NONE && last_q) begin
        len_q[sel_q] <= LenW'(addr_q) + 1'b1;
      end
      if (op == OP_RPM_UPD) begin
        rpm_q <= rising ? rpm_q + RpmW'(prod_q[39:24]) : rpm_q - RpmW'(prod_q[39:24]);
      end
      if (op == OP_BAND) band_q <= band_new;
      if (op == OP_MOD_WAIT && div_done) phase_q[lp_q] <= div_rem[PhaseW-1:0];
      if (op == OP_OUT && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.capture) begin
      func_q <= item_func_i;
      rev_q  <= item_rev_up_i;
      sel_q  <= item_loop_select_i;
      addr_q <= item_word_address_i;
      wval_q <= item_word_value_i;
      last_q <= item_last_word_i;
    end
    case (op)
      OP_BAND: begin
        lp_q     <= band_new;
        second_q <= 1'b0;
        lerp_q   <= '0;
      end
      OP_INC_WAIT:  if (div_done) inc_q <= div_quot[RpmW-1:0];
      OP_RD_B:      a_q <= ram_rdata;
      OP_RD_END:    b_q <= ram_rdata;
      OP_ISUM:      i_q <= isum[16:0];
      OP_GSTO: begin
        if (second_q) wb_q <= prod_q[33:0];
        else wa_q <= prod_q[33:0];
        if (two_loops && !second_q) begin
          lp_q     <= lp_q + 1'b1;
          second_q <= 1'b1;
        end
      end
      OP_LERP_WAIT: if (div_done) lerp_q <= lx[25] ? 26'(-div_quot[25:0]) : div_quot[25:0];
      OP_MIX_H:     acc_q <= $signed({{14{wa_q[33]}}, wa_q, 16'd0})
                             + $signed({{11{prod_q[52]}}, prod_q});
      OP_MIX_SUM:   acc_q <= acc_q + $signed({prod_q[47:0], 16'd0});
      OP_OUT: if (!out_valid_q || out_ready_i) begin
        out_sample_q <= sat;
        out_band_q   <= band_q;
      end
      default: ;
    endcase
  end

  assign status_o.div_done  = div_done;
  assign status_o.func      = func_q;
  assign status_o.two_loops = two_loops;
  assign status_o.second    = second_q;
  assign status_o.lerp_ok   = lerp_ok;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign out_band_o   = out_band_q;

endmodule

// ===== hdl/engine_sound_wavetable_synth.sv =====
// ----------------------------------------------------------------------------
// engine_sound_wavetable_synth
// three looped wave tables crossfaded by a smoothed engine rpm
// ----------------------------------------------------------------------------
// A word with tuser = 1 loads one 16-bit sample into loop loop_select (loop
// three is ignored); tlast sets that loop's length to address plus one. A load
// gives no result. A word with tuser = 0 produces one output word: the rpm
// moves toward 120 or 25, the band steps by at most one, the active loop and,
// below the top band, its upper neighbour advance and are interpolated, gained
// and crossfaded. The work on a sample is set by the single shared bit-serial
// divider (two divides per loop for phase step and wrap, one for the crossfade
// factor, skipped when the loop rpms are out of order) and by the single-port
// wave memory read twice per loop; the result waits until the output is free.
// Input is taken only between items; a finished result waits in the output
// register while the next word is accepted. The wave memory has no reset.
module engine_sound_wavetable_synth (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config write port
  input  logic                         cfg_we_i,
  input  logic [esw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [esw_pkg::CfgDataW-1:0] cfg_data_i,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [39:0]                  s_axis_tdata,  // rev_up, loop_select, word_address,
                                                      // word_value, zero fill
  input  logic [0:0]                   s_axis_tuser,  // func
  input  logic                         s_axis_tlast,  // last_word
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata,  // sample
  output logic [1:0]                   m_axis_tuser   // band
);
  import esw_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  esw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath with wave memory, multiplier and divider
  esw_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .item_func_i         (s_axis_tuser[0]),
    .item_rev_up_i       (s_axis_tdata[0]),
    .item_loop_select_i  (s_axis_tdata[2:1]),
    .item_word_address_i (s_axis_tdata[16:3]),
    .item_word_value_i   (s_axis_tdata[32:17]),
    .item_last_word_i    (s_axis_tlast),
    .out_valid_o         (m_axis_tvalid),
    .out_ready_i         (m_axis_tready),
    .out_sample_o        (m_axis_tdata),
    .out_band_o          (m_axis_tuser)
  );

`ifndef SYNTHESIS
  // a word in flight blocks further input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while busy");

  // a new result only follows work on an accepted word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without work");

  // band stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3))
    else $error("band out of range");
`endif

endmodule

// ===== test/tb_engine_sound_wavetable_synth.sv =====
// ----------------------------------------------------------------------------
// tb_engine_sound_wavetable_synth
// self-checking stream test of the rpm-crossfaded wavetable synth
// ----------------------------------------------------------------------------
// Short loops are loaded first so that no read ever hits an unwritten table
// entry. A directed part and then random phases follow. Register settings
// change only between phases, once the block is idle. A local model of rpm,
// band, phase and mix predicts every sample word, and the monitor compares
// the output words in order. Both sides idle at random. The receiver also
// holds off for one long stretch so that the input stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_engine_sound_wavetable_synth;
  import esw_pkg::*;

  localparam int unsigned DEPTH = LoopDepth;

  typedef struct packed {
    logic        func;
    logic        rev_up;
    logic [1:0]  sel;
    logic [13:0] addr;
    logic [15:0] val;
    logic        last;
  } word_t;

  typedef struct packed {
    logic [15:0] smp;
    logic [1:0]  bnd;
  } mix_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  engine_sound_wavetable_synth DUT (.*);

  always #2 clk_i = ~clk_i;

  // model state: registers, rpm, band, phases, lengths, tables
  longint lr_reg[3];
  longint gain_reg[3];
  longint rate_reg;
  longint rpm_q16;
  int     band_q;
  longint phase_q[3];
  longint len_q[3];
  logic signed [15:0] wave_q[0:3*DEPTH-1];

  // generation-side bookkeeping: which table entries have been written
  bit     written[3][DEPTH];
  int     filled[3];

  word_t  pending_words[$];
  mix_t   expected_mix[$];
  int     errors = 0;
  int     n_samples = 0, n_loads = 0;
  int     band_hits[3] = '{0, 0, 0};

  // ---------------------------------------------------------------- model
  function automatic void step_phase(int lp);
    longint lr, inc;
    lr = (lr_reg[lp] == 0) ? 1 : lr_reg[lp];
    inc = rpm_q16 / lr;
    phase_q[lp] = (phase_q[lp] + inc) % (len_q[lp] << 16);
  endfunction

  function automatic longint lerp_sample(int lp);
    longint idx, nx, f, ua, ub;
    idx = (phase_q[lp] >> 16) % len_q[lp];
    nx  = (idx + 1) % len_q[lp];
    f   = phase_q[lp] & 64'hFFFF;
    ua  = longint'(wave_q[lp*DEPTH + idx]) + 32768;
    ub  = longint'(wave_q[lp*DEPTH + nx]) + 32768;
    return ((ua * (65536 - f) + ub * f) >> 16) - 32768;
  endfunction

  function automatic mix_t synth_tick(logic rev);
    longint tgt, d, wa, wb, xf, den, v, s;
    int b;
    mix_t r;
    tgt = (rev ? longint'(MaxRpm) : longint'(MinRpm)) << 16;
    if (tgt >= rpm_q16) begin
      d = tgt - rpm_q16;
      rpm_q16 = rpm_q16 + ((d * rate_reg) >> 24);
    end else begin
      d = rpm_q16 - tgt;
      rpm_q16 = rpm_q16 - ((d * rate_reg) >> 24);
    end
    rpm_q16 = rpm_q16 & 64'hFFFFFF;
    b = band_q;
    if (b < 2 && rpm_q16 > (lr_reg[b+1] << 16)) b++;
    else if (b != 0 && rpm_q16 < (lr_reg[b] << 16)) b--;
    band_q = b;
    step_phase(b);
    wa = lerp_sample(b) * gain_reg[b];
    if (b < 2) begin
      step_phase(b + 1);
      xf = 0;
      den = lr_reg[b+1] - lr_reg[b];
      if (den > 0) xf = (rpm_q16 - (lr_reg[b] << 16)) / den;
      wb = lerp_sample(b + 1) * gain_reg[b+1];
      v = wa * (65536 - xf) + wb * xf;
    end else begin
      v = wa * 65536;
    end
    s = v / (longint'(1) << 31);
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    r.smp = s[15:0];
    r.bnd = b[1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers
  task automatic push_load(logic [1:0] sel, logic [13:0] addr, logic [15:0] val, bit last);
    word_t w;
    if (sel != LOOP_NONE) begin
      written[sel][addr] = 1'b1;
      while (filled[sel] < DEPTH && written[sel][filled[sel]]) filled[sel]++;
      // a length is only set over a fully written prefix
      if (last && addr >= filled[sel]) last = 0;
    end
    w = '{func: 1'b1, rev_up: 1'($urandom_range(0, 1)), sel: sel, addr: addr,
          val: val, last: last};
    pending_words.push_back(w);
  endtask

  task automatic push_tick(logic rev);
    word_t w;
    w = '{func: FUNC_SAMPLE, rev_up: rev, sel: 2'($urandom_range(0, 3)),
          addr: 14'($urandom), val: 16'($urandom), last: 1'($urandom_range(0, 1))};
    pending_words.push_back(w);
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    #1;
    while (pending_words.size() != 0 || s_axis_tvalid || expected_mix.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
    // a load may still be in flight with nothing expected
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx <= CFG_LOOP_RPM_HIGH) lr_reg[idx] = data[7:0];
    else if (idx <= CFG_GAIN_HIGH) gain_reg[idx - CFG_GAIN_LOW] = data;
    else if (idx == CFG_APPROACH_RATE) rate_reg = data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all(int l0, int l1, int l2, int g0, int g1, int g2, int rt);
    wait_idle();
    write_reg(CFG_LOOP_RPM_LOW, CfgDataW'(l0));
    write_reg(CFG_LOOP_RPM_MID, CfgDataW'(l1));
    write_reg(CFG_LOOP_RPM_HIGH, CfgDataW'(l2));
    write_reg(CFG_GAIN_LOW, CfgDataW'(g0));
    write_reg(CFG_GAIN_MID, CfgDataW'(g1));
    write_reg(CFG_GAIN_HIGH, CfgDataW'(g2));
    write_reg(CFG_APPROACH_RATE, CfgDataW'(rt));
  endtask

  // random phase: runs of rev_up so the rpm sweeps across bands, loads mixed in
  task automatic random_phase(int n);
    bit rev;
    int run;
    logic [13:0] a;
    run = 0;
    rev = 1;
    for (int i = 0; i < n; i++) begin
      if (run == 0) begin
        rev = ~rev;
        run = $urandom_range(5, 80);
      end
      run--;
      if ($urandom_range(0, 3) == 0) begin
        a = ($urandom_range(0, 4) == 0) ? 14'($urandom) : 14'($urandom_range(0, 40));
        push_load(2'($urandom_range(0, 3)), a, 16'($urandom), $urandom_range(0, 5) == 0);
      end else begin
        push_tick(rev);
      end
    end
  endtask

  // ---------------------------------------------------------------- driver
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        word_t w;
        w = pending_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, w.val, w.addr, w.sel, w.rev_up};
        s_axis_tuser  <= w.func;
        s_axis_tlast  <= w.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // accepted input word: update the model, queue the expected sample word
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      if (s_axis_tuser[0] == FUNC_SAMPLE) begin
        mix_t m;
        m = synth_tick(s_axis_tdata[0]);
        expected_mix.push_back(m);
        n_samples++;
        band_hits[m.bnd]++;
      end else begin
        n_loads++;
        if (s_axis_tdata[2:1] != LOOP_NONE) begin
          wave_q[s_axis_tdata[2:1]*DEPTH + s_axis_tdata[16:3]] = s_axis_tdata[32:17];
          if (s_axis_tlast) len_q[s_axis_tdata[2:1]] = longint'(s_axis_tdata[16:3]) + 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  int rx_cycle = 0;
  int rx_mode = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 500 == 0) rx_mode <= $urandom_range(0, 2);
      // one long hold-off so the output register fills and the input stalls
      if (rx_cycle >= 20000 && rx_cycle < 23000) m_axis_tready <= 1'b0;
      else if (rx_mode == 0) m_axis_tready <= 1'b1;
      else if (rx_mode == 1) m_axis_tready <= ($urandom_range(0, 9) < 7);
      else m_axis_tready <= ($urandom_range(0, 9) < 3);
    end
  end

  // monitor: compare each output word with the oldest expected sample word
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_mix.size() == 0) begin
        $error("unexpected output word: sample %h band %0d", m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        mix_t m;
        m = expected_mix.pop_front();
        if (m_axis_tdata !== m.smp) begin
          $error("sample: expected %h, actual %h", m.smp, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== m.bnd) begin
          $error("band: expected %0d, actual %0d", m.bnd, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    lr_reg   = '{LrLowRst, LrMidRst, LrHighRst};
    gain_reg = '{GainLowRst, GainMidRst, GainHiRst};
    rate_reg = RateRst;
    rpm_q16  = longint'(MinRpm) << 16;
    band_q   = 0;
    for (int i = 0; i < 3; i++) begin
      phase_q[i] = 0;
      len_q[i]   = DEPTH;
      filled[i]  = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // short loops first, extreme sample values inside them
    for (int lp = 0; lp < 3; lp++)
      for (int a = 0; a < 4; a++)
        push_load(2'(lp), 14'(a),
                  (a == 0) ? 16'h8000 : (a == 1) ? 16'h7FFF : 16'($urandom), a == 3);
    push_load(LOOP_NONE, 14'h3FFF, 16'h7FFF, 1);  // loop three is ignored
    push_load(2'd0, 14'h3FFF, 16'h8000, 0);       // top address, no length change
    for (int i = 0; i < 4; i++) push_tick(1);
    for (int i = 0; i < 4; i++) push_tick(0);
    push_load(2'd1, 14'd1, 16'h8000, 1);          // shorten a loop below its phase
    push_tick(1);
    push_tick(0);

    random_phase(90);
    // fast approach, narrow low crossfade, wide middle crossfade, zero middle gain
    set_all(1, 2, 255, 32768, 0, 32768, 65535);
    random_phase(130);
    // zero and disordered loop rpms, zero approach rate
    set_all(0, 255, 254, 0, 32768, 32768, 0);
    random_phase(60);
    wait_idle();
    write_reg(CFG_APPROACH_RATE, 16'hFFFF);
    write_reg(3'd7, 16'hFFFF);                    // index past the list is ignored
    random_phase(110);
    set_all(255, 255, 255, 32768, 32768, 32768, 65535);
    random_phase(70);
    set_all(25, 40, 65, 32768, 32768, 32768, 20000);
    random_phase(130);
    set_all(30, 60, 100, 12345, 32768, 7000, 65535);
    random_phase(140);

    wait_idle();
    repeat (300) @(posedge clk_i);
    if (expected_mix.size() != 0) begin
      $error("%0d expected sample words never came", expected_mix.size());
      errors++;
    end
    $display("covered %0d sample ticks and %0d table loads over six register settings",
             n_samples, n_loads);
    $display("band use: low %0d, middle %0d, top %0d", band_hits[0], band_hits[1],
             band_hits[2]);
    if (errors == 0) begin
      $display("** engine_sound_wavetable_synth: PASSED **");
    end else begin
      $display("** engine_sound_wavetable_synth: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** engine_sound_wavetable_synth: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/esw_pkg.sv
hdl/esw_ram.sv
hdl/esw_div.sv
hdl/esw_ctrl.sv
hdl/esw_dp.sv
hdl/engine_sound_wavetable_synth.sv
test/tb_engine_sound_wavetable_synth.sv
